// ===== rtl/core/rrle_pkg.sv =====
// Shared types and constants for the raster RLE byte decoder.
// No dependencies; imported by rrle_ctrl, rrle_dp and raster_rle_byte_decoder.
package rrle_pkg;

	localparam int BYTE_W       = 8;
	localparam int LEN_W        = 9;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;

	localparam logic [BYTE_W-1:0] ESCAPE_BYTE    = 8'h80;
	localparam logic [CFG_W-1:0]  MIN_LINE_BYTES = 16'd16;
	localparam logic [CFG_W-1:0]  RST_LINE_BYTES = 16'd16;
	localparam logic [CFG_W-1:0]  RST_LINE_TOTAL = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_BYTES = 2'd0,
		REG_LINE_TOTAL = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic take_byte;
		logic emit_piece;
	} ctrl_cmd_t;

	typedef struct packed {
		logic run_start;
		logic piece_last;
	} dp_status_t;

endpackage

// ===== rtl/core/raster_rle_byte_decoder.sv =====
// Top level of the raster RLE byte decoder: ties controller and datapath to the ports.
// Depends on rrle_pkg, rrle_ctrl and rrle_dp.
//
// Decodes an escape-coded byte stream (0x80 escape; escape 0 is a literal 0x80,
// escape n v is n+1 copies of v) into run pieces cut at line ends, marked with
// end_of_line, end_of_image and last. A byte that decodes to a run holds the
// input while its pieces are emitted. The piece loop runs through one shared
// subtract/compare unit, one piece per cycle while the output register is free,
// and a full output register lets the next byte be taken while the last beat
// waits. Escape and count bytes produce no beat. Configuration writes are
// taken every cycle (cfg_ready is tied high); index 0 sets line_bytes (below
// 16 reads as 16), index 1 sets line_total (0 reads as 1).
module raster_rle_byte_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrle_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rrle_pkg::BYTE_W-1:0]    in_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rrle_pkg::BYTE_W-1:0]    run_value,
	output logic [rrle_pkg::LEN_W-1:0]     run_length,
	output logic                           end_of_line,
	output logic                           end_of_image,
	output logic                           last
);
	import rrle_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rrle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rrle_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_byte      (in_byte),
		.cmd          (cmd),
		.status       (status),
		.run_value    (run_value),
		.run_length   (run_length),
		.end_of_line  (end_of_line),
		.end_of_image (end_of_image),
		.last         (last)
	);

endmodule

// ===== rtl/core/rrle_ctrl.sv =====
// Controller for the raster RLE byte decoder: byte intake and piece emission sequencing.
// Owns the output valid flag. Depends on rrle_pkg.
module rrle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rrle_pkg::dp_status_t status,
	output rrle_pkg::ctrl_cmd_t  cmd
);
	import rrle_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take_byte && status.run_start)
					state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.emit_piece && status.piece_last)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.take_byte  = 1'b0;
		cmd.emit_piece = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take_byte = in_valid;
			end
			ST_RUN: begin
				cmd.emit_piece = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit_piece)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/rrle_dp.sv =====
// Datapath for the raster RLE byte decoder: escape decode, line/image counters,
// run splitting and the output beat register. Depends on rrle_pkg.
module rrle_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [rrle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrle_pkg::CFG_W-1:0]     cfg_data,
	input  logic [rrle_pkg::BYTE_W-1:0]    in_byte,
	input  rrle_pkg::ctrl_cmd_t            cmd,
	output rrle_pkg::dp_status_t           status,
	output logic [rrle_pkg::BYTE_W-1:0]    run_value,
	output logic [rrle_pkg::LEN_W-1:0]     run_length,
	output logic                          end_of_line,
	output logic                          end_of_image,
	output logic                          last
);
	import rrle_pkg::*;

	logic [CFG_W-1:0]  line_bytes_q, line_total_q;
	phase_t            phase_q;
	logic [BYTE_W-1:0] pending_q;
	logic [CFG_W-1:0]  pos_q, idx_q;
	logic [BYTE_W-1:0] value_q;
	logic [LEN_W-1:0]  remain_q;

	// byte decode
	phase_t            phase_nxt;
	logic [BYTE_W-1:0] pending_nxt;
	logic              run_start;
	logic [BYTE_W-1:0] run_val_nxt;
	logic [LEN_W-1:0]  run_len_nxt;

	always_comb begin
		phase_nxt   = PH_PLAIN;
		pending_nxt = '0;
		run_start   = 1'b0;
		run_val_nxt = in_byte;
		run_len_nxt = LEN_W'(1);
		unique case (phase_q)
			PH_ESC: begin
				if (in_byte == '0) begin
					run_start   = 1'b1;
					run_val_nxt = ESCAPE_BYTE;
				end else begin
					phase_nxt   = PH_VALUE;
					pending_nxt = in_byte;
				end
			end
			PH_VALUE: begin
				run_start   = 1'b1;
				run_len_nxt = {1'b0, pending_q} + LEN_W'(1);
			end
			default: begin
				if (in_byte == ESCAPE_BYTE)
					phase_nxt = PH_ESC;
				else
					run_start = 1'b1;
			end
		endcase
	end

	// piece split against the current line
	logic [CFG_W-1:0] width, lines, room;
	logic [LEN_W-1:0] piece, remain_nxt;
	logic [CFG_W:0]   pos_sum, idx_inc;
	logic             eol, eoi;

	always_comb begin
		width = (line_bytes_q < MIN_LINE_BYTES) ? MIN_LINE_BYTES : line_bytes_q;
		lines = (line_total_q == '0) ? CFG_W'(1) : line_total_q;
		// position left past the line end by a config change: one byte closes it
		room  = (pos_q < width) ? (width - pos_q) : CFG_W'(1);
		if (CFG_W'(remain_q) < room)
			piece = remain_q;
		else
			piece = room[LEN_W-1:0];
		pos_sum    = {1'b0, pos_q} + (CFG_W+1)'(piece);
		idx_inc    = {1'b0, idx_q} + (CFG_W+1)'(1);
		eol        = (pos_sum >= {1'b0, width}) || (CFG_W'(piece) == room);
		eoi        = eol && (idx_inc >= {1'b0, lines});
		remain_nxt = eoi ? '0 : (remain_q - piece);
	end

	assign status.run_start  = run_start;
	assign status.piece_last = (remain_nxt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= RST_LINE_BYTES;
			line_total_q <= RST_LINE_TOTAL;
			phase_q      <= PH_PLAIN;
			pending_q    <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_LINE_BYTES)
					line_bytes_q <= cfg_data;
				else if (cfg_index == REG_LINE_TOTAL)
					line_total_q <= cfg_data;
			end
			if (cmd.take_byte) begin
				phase_q   <= phase_nxt;
				pending_q <= pending_nxt;
			end else if (cmd.emit_piece) begin
				if (eoi) begin
					phase_q   <= PH_PLAIN;
					pending_q <= '0;
				end
				if (eol)
					pos_q <= '0;
				else
					pos_q <= pos_sum[CFG_W-1:0];
				if (eoi)
					idx_q <= '0;
				else if (eol)
					idx_q <= idx_inc[CFG_W-1:0];
			end
		end
	end

	// run registers and output beat register
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			value_q  <= run_val_nxt;
			remain_q <= run_len_nxt;
		end else if (cmd.emit_piece) begin
			remain_q <= remain_nxt;
		end
		if (cmd.emit_piece) begin
			run_value    <= value_q;
			run_length   <= piece;
			end_of_line  <= eol;
			end_of_image <= eoi;
			last         <= (remain_nxt == '0);
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for raster_rle_byte_decoder: directed table, then random image streams.
// Depends on rrle_pkg and the decoder RTL; predicts run pieces with its own line/image tracker.
module tb_top;
	import rrle_pkg::*;

	localparam int CYC_LIMIT   = 500000;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int DIR_ROWS    = 32;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 35;
	localparam int MAX_PIECES  = 17;

	typedef struct packed {
		logic [BYTE_W-1:0] run_val;
		logic [LEN_W-1:0]  run_len;
		logic              eol;
		logic              eoi;
		logic              last;
	} piece_t;

	typedef struct packed {
		logic              is_cfg;
		cfg_reg_t          reg_sel;
		logic [CFG_W-1:0]  cfg_val;
		logic [BYTE_W-1:0] dat;
		logic              typed;
		piece_t            want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    in_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [BYTE_W-1:0]    run_value;
	logic [LEN_W-1:0]     run_length;
	logic                 end_of_line;
	logic                 end_of_image;
	logic                 last;

	// predictor state
	logic [CFG_W-1:0]  line_bytes_q;
	logic [CFG_W-1:0]  line_total_q;
	phase_t            dec_phase;
	logic [BYTE_W-1:0] run_count;
	int unsigned       line_pos;
	int unsigned       line_idx;

	piece_t fresh_q[$];
	piece_t pending_pieces[$];
	row_t   dir_tab [DIR_ROWS];

	logic [CFG_W-1:0] lb_set [PHASES] = '{16'd16, 16'd0, 16'd31, 16'd65535, 16'd40, 16'd17};
	logic [CFG_W-1:0] lt_set [PHASES] = '{16'd3, 16'd0, 16'd2, 16'd1, 16'd65535, 16'd4};

	int     err_cnt;
	int     cyc;
	int     burst_left;
	logic   hold_req;
	piece_t got_want;

	raster_rle_byte_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.run_value    (run_value),
		.run_length   (run_length),
		.end_of_line  (end_of_line),
		.end_of_image (end_of_image),
		.last         (last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Cut one decoded run into pieces at line ends; image end drops the remainder.
	function automatic void expand_run(input logic [BYTE_W-1:0] v, input int unsigned len);
		int unsigned width;
		int unsigned lines;
		int unsigned room;
		int unsigned piece;
		int          n;
		piece_t      p;
		width = (line_bytes_q < MIN_LINE_BYTES) ? 16 : line_bytes_q;
		lines = (line_total_q == 0) ? 1 : line_total_q;
		n = 0;
		while (len > 0 && n < MAX_PIECES) begin
			room = (line_pos < width) ? width - line_pos : 1;
			piece = (len < room) ? len : room;
			len -= piece;
			line_pos += piece;
			p.eol = 1'b0;
			p.eoi = 1'b0;
			if (line_pos >= width || piece == room) begin
				p.eol = 1'b1;
				line_pos = 0;
				line_idx = (line_idx + 1) & 32'h1ffff;
				if (line_idx >= lines) begin
					p.eoi = 1'b1;
					line_idx = 0;
					dec_phase = PH_PLAIN;
					run_count = '0;
					len = 0;
				end
			end
			p.run_val = v;
			p.run_len = LEN_W'(piece);
			p.last = (len == 0);
			fresh_q.push_back(p);
			n++;
		end
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		int unsigned len;
		fresh_q.delete();
		case (dec_phase)
			PH_ESC: begin
				if (b == '0) begin
					dec_phase = PH_PLAIN;
					expand_run(ESCAPE_BYTE, 1);
				end else begin
					run_count = b;
					dec_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				len = int'(run_count) + 1;
				dec_phase = PH_PLAIN;
				run_count = '0;
				expand_run(b, len);
			end
			default: begin
				dec_phase = PH_PLAIN;
				if (b == ESCAPE_BYTE)
					dec_phase = PH_ESC;
				else
					expand_run(b, 1);
			end
		endcase
	endfunction

	function automatic row_t byte_row(input logic [BYTE_W-1:0] b);
		row_t r;
		r = '0;
		r.dat = b;
		return r;
	endfunction

	// single-piece result, readable straight off the stream
	function automatic row_t chk_row(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] v,
			input int len, input logic eol, input logic eoi);
		row_t r;
		r = '0;
		r.dat = b;
		r.typed = 1'b1;
		r.want = '{v, LEN_W'(len), eol, eoi, 1'b1};
		return r;
	endfunction

	function automatic row_t cfg_row(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_sel = sel;
		r.cfg_val = val;
		return r;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed, input piece_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		in_byte = b;
		do @(posedge clk); while (!in_ready);
		decode_byte(b);
		if (typed)
			pending_pieces.push_back(want);
		else
			foreach (fresh_q[i]) pending_pieces.push_back(fresh_q[i]);
	endtask

	// drain all expected beats, then settle; escape and count bytes give no beat
	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pieces.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			REG_LINE_BYTES: line_bytes_q = val;
			REG_LINE_TOTAL: line_total_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		cyc++;
		if (cyc == CYC_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_pieces.size() == 0) begin
				$error("unexpected beat: run_value %0h run_length %0d", run_value, run_length);
				err_cnt++;
			end else begin
				got_want = pending_pieces.pop_front();
				if (run_value !== got_want.run_val) begin
					$error("run_value: expected %0h, got %0h", got_want.run_val, run_value);
					err_cnt++;
				end
				if (run_length !== got_want.run_len) begin
					$error("run_length: expected %0d, got %0d", got_want.run_len, run_length);
					err_cnt++;
				end
				if (end_of_line !== got_want.eol) begin
					$error("end_of_line: expected %0b, got %0b", got_want.eol, end_of_line);
					err_cnt++;
				end
				if (end_of_image !== got_want.eoi) begin
					$error("end_of_image: expected %0b, got %0b", got_want.eoi, end_of_image);
					err_cnt++;
				end
				if (last !== got_want.last) begin
					$error("last: expected %0b, got %0b", got_want.last, last);
					err_cnt++;
				end
			end
		end
	end

	// output side: random stall modes, plus one long hold-off on request
	initial begin : sink_proc
		int         mode;
		int         span;
		int         hold;
		logic [7:0] mask;
		logic       hold_seen;
		out_ready = 1'b0;
		mode = 0;
		span = 0;
		hold = 0;
		mask = 8'hff;
		hold_seen = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(16, 96);
				mask = 8'($urandom_range(1, 255));
			end
			span--;
			mask = {mask[6:0], mask[7]};
			if (hold > 0) begin
				hold--;
				out_ready = 1'b0;
			end else begin
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = ($urandom_range(0, 1) == 1);
					2: out_ready = ($urandom_range(0, 3) == 0);
					default: out_ready = mask[0];
				endcase
			end
		end
	end

	initial begin : main_proc
		int   ph;
		int   sent;
		int   pick;
		logic [BYTE_W-1:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LINE_BYTES;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		line_bytes_q = RST_LINE_BYTES;
		line_total_q = RST_LINE_TOTAL;
		dec_phase = PH_PLAIN;
		run_count = '0;
		line_pos = 0;
		line_idx = 0;

		dir_tab = '{
			chk_row(8'h00, 8'h00, 1, 1'b0, 1'b0),
			chk_row(8'hff, 8'hff, 1, 1'b0, 1'b0),
			chk_row(8'h7f, 8'h7f, 1, 1'b0, 1'b0),
			chk_row(8'h81, 8'h81, 1, 1'b0, 1'b0),
			byte_row(ESCAPE_BYTE),
			chk_row(8'h00, ESCAPE_BYTE, 1, 1'b0, 1'b0),
			byte_row(ESCAPE_BYTE), byte_row(8'h02), byte_row(8'h55),
			// longest run starts mid-line and hits the image end at that line's end; rest is dropped
			byte_row(ESCAPE_BYTE), byte_row(8'hff), byte_row(8'haa),
			cfg_row(REG_LINE_BYTES, 16'd0),
			cfg_row(REG_LINE_TOTAL, 16'd0),
			byte_row(ESCAPE_BYTE), byte_row(8'h0f),
			chk_row(8'h11, 8'h11, 16, 1'b1, 1'b1),
			cfg_row(REG_LINE_BYTES, 16'd16),
			cfg_row(REG_LINE_TOTAL, 16'd65535),
			byte_row(ESCAPE_BYTE), byte_row(8'hff), byte_row(8'h33),
			cfg_row(REG_LINE_BYTES, 16'd100),
			byte_row(ESCAPE_BYTE), byte_row(8'h13), byte_row(8'h44),
			// shrink the line under the current position
			cfg_row(REG_LINE_BYTES, 16'd16),
			chk_row(8'h09, 8'h09, 1, 1'b1, 1'b0),
			// shrink the image under the current line index
			cfg_row(REG_LINE_TOTAL, 16'd3),
			byte_row(ESCAPE_BYTE), byte_row(8'h1f),
			chk_row(8'h66, 8'h66, 16, 1'b1, 1'b1)
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_drain();
				write_cfg(dir_tab[i].reg_sel, dir_tab[i].cfg_val);
			end else begin
				send_byte(dir_tab[i].dat, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			write_cfg(REG_LINE_BYTES, lb_set[ph]);
			write_cfg(REG_LINE_TOTAL, lt_set[ph]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// escape, count, value; counts mostly short
					v = ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom_range(1, 20))
						: BYTE_W'($urandom_range(1, 255));
					send_byte(ESCAPE_BYTE, 1'b0, '0);
					send_byte(v, 1'b0, '0);
					send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
					sent += 3;
				end else if (pick < 60) begin
					send_byte(ESCAPE_BYTE, 1'b0, '0);
					send_byte(8'h00, 1'b0, '0);
					sent += 2;
				end else if (pick < 90) begin
					send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
					sent++;
				end else begin
					v = ($urandom_range(0, 2) == 0) ? ESCAPE_BYTE : BYTE_W'($urandom_range(0, 255));
					send_byte(v, 1'b0, '0);
					sent++;
				end
				if (ph == 1 && !hold_req && sent >= 1 && sent <= 3)
					hold_req = 1'b1;
				if (ph == 3 && sent >= 18 && sent <= 20)
					wait_drain();
			end
		end

		wait_drain();
		if (err_cnt == 0 && pending_pieces.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
